>>> design/lhdu_pkg.sv
// Shared types and constants for the LCD header digit updater.
`default_nettype none
package lhdu_pkg;

   // Channel widths (fields packed from bit 0, padded to whole bytes)
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 16;

   // Display layout
   localparam int CELL_COUNT  = 5;
   localparam int FIXED_COUNT = 4;
   localparam int STEP_COUNT  = FIXED_COUNT + CELL_COUNT;

   // Default depth of the queue between front and back
   localparam int QUEUE_DEPTH_DEF = 2;

   // Character codes
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_DEGREE  = 8'h00;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_DASH    = 8'h2D;
   localparam logic [7:0] CHAR_EMPTY   = 8'hFF;
   localparam logic [3:0] DIGIT_HI     = 4'h3;

   // Saturation limits and reciprocal constants
   localparam logic [9:0]  DISP_MAX_TENTHS = 10'd999;
   localparam logic [6:0]  HUM_MAX         = 7'd99;
   localparam logic [11:0] F_OFFSET        = 12'd320;
   localparam logic [15:0] RECIP10_19      = 16'd52429;  // 2^19 / 10, rounded up
   localparam logic [10:0] RECIP10_11      = 11'd205;    // 2^11 / 10, rounded up
   localparam logic [6:0]  RECIP100_12     = 7'd41;      // 2^12 / 100, rounded up

   // Write order: the four fixed symbols, then the five digit cells
   localparam logic [STEP_COUNT-1:0][3:0] STEP_COLUMN =
      {4'd8, 4'd7, 4'd4, 4'd2, 4'd1, 4'd9, 4'd6, 4'd5, 4'd3};
   localparam logic [FIXED_COUNT-1:0][7:0] FIXED_CHAR =
      {CHAR_PERCENT, CHAR_SPACE, CHAR_DEGREE, CHAR_DOT};

   // One unit of work for the back end
   typedef struct packed {
      logic                           full;   // fixed symbols plus all cells
      logic [CELL_COUNT-1:0]          mask;   // cells to write
      logic [CELL_COUNT-1:0][7:0]     chars;  // cell characters
   } q_entry_type;

endpackage
`default_nettype wire

>>> design/lhdu_front.sv
// Front end: accepts requests, formats the characters, tracks shown cells.
`default_nettype none
module lhdu_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [9:0] temp_tenths_c, [16:10] humidity_pct, [17] sensor_failed, [23:18] zero
   input  logic [lhdu_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [0] kind
   input  logic                                req_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_data,
   output logic                                push_valid,
   output lhdu_pkg::q_entry_type               push_entry,
   input  logic                                q_full
);
   import lhdu_pkg::*;

   logic        fmode_ff, fmode_in;
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_kind_ff, s1_failed_ff;
   logic [9:0]  s1_v_ff;
   logic [6:0]  s1_hum_ff;
   logic        restore_ff, restore_in;
   logic [CELL_COUNT-1:0][7:0] shown_ff, shown_in;

   logic        req_fire, s1_fire;
   logic [9:0]  temp_c;
   logic [6:0]  hum_raw;
   logic [14:0] f_x;
   logic [30:0] f_prod;
   logic [11:0] f_v, v_sel;
   logic [9:0]  v_sat;
   logic [6:0]  hum_sat;

   logic [15:0] tens_prod;
   logic [17:0] ti_prod;
   logic [14:0] hum_prod;
   logic [3:0]  t_tens, t_units, t_frac, h_tens, h_units;
   logic [6:0]  t_int;
   logic [CELL_COUNT-1:0][7:0] cell_chars;
   logic [CELL_COUNT-1:0]      cell_diff;

   // Configuration register, always ready
   assign csr_ready = 1'b1;
   assign fmode_in  = (csr_valid && csr_ready) ? csr_data : fmode_ff;

   // Accept stage: temperature conversion and saturation
   assign req_tready = !s1_valid_ff || !q_full;
   assign req_fire   = req_tvalid && req_tready;
   assign s1_fire    = s1_valid_ff && !q_full;
   assign temp_c     = req_tdata[9:0];
   assign hum_raw    = req_tdata[16:10];

   always_comb begin
      f_x     = 15'({temp_c, 4'b0}) + 15'({temp_c, 1'b0}) + 15'd5;
      f_prod  = 31'(f_x) * 31'(RECIP10_19);
      f_v     = f_prod[30:19] + F_OFFSET;
      v_sel   = fmode_ff ? f_v : 12'(temp_c);
      v_sat   = (v_sel > 12'(DISP_MAX_TENTHS)) ? DISP_MAX_TENTHS : v_sel[9:0];
      hum_sat = (hum_raw > HUM_MAX) ? HUM_MAX : hum_raw;
   end

   assign s1_valid_in = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

   // Second stage: digit split by reciprocal multiply
   always_comb begin
      tens_prod = 16'(s1_v_ff) * 16'(RECIP100_12);
      ti_prod   = 18'(s1_v_ff) * 18'(RECIP10_11);
      hum_prod  = 15'(s1_hum_ff) * 15'(RECIP10_11);
      t_tens    = tens_prod[15:12];
      t_int     = ti_prod[17:11];
      t_units   = 4'(t_int - 7'(t_tens) * 7'd10);
      t_frac    = 4'(s1_v_ff - 10'(t_int) * 10'd10);
      h_tens    = hum_prod[14:11];
      h_units   = 4'(s1_hum_ff - 7'(h_tens) * 7'd10);
   end

   // Cell characters: blank leading tens, dashes on failure
   always_comb begin
      if (s1_failed_ff) begin
         cell_chars = {CELL_COUNT{CHAR_DASH}};
      end else begin
         cell_chars[0] = (t_tens != 4'd0) ? {DIGIT_HI, t_tens} : CHAR_SPACE;
         cell_chars[1] = {DIGIT_HI, t_units};
         cell_chars[2] = {DIGIT_HI, t_frac};
         cell_chars[3] = (h_tens != 4'd0) ? {DIGIT_HI, h_tens} : CHAR_SPACE;
         cell_chars[4] = {DIGIT_HI, h_units};
      end
      for (int i = 0; i < CELL_COUNT; i++) begin
         cell_diff[i] = (cell_chars[i] != shown_ff[i]);
      end
   end

   // Display state update and queue push
   always_comb begin
      restore_in       = restore_ff;
      shown_in         = shown_ff;
      push_valid       = 1'b0;
      push_entry.full  = restore_ff;
      push_entry.mask  = restore_ff ? {CELL_COUNT{1'b1}} : cell_diff;
      push_entry.chars = cell_chars;
      if (s1_fire) begin
         if (s1_kind_ff) begin
            restore_in = 1'b1;
         end else begin
            restore_in = 1'b0;
            shown_in   = cell_chars;
            push_valid = restore_ff || (cell_diff != '0);
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fmode_ff    <= 1'b0;
         s1_valid_ff <= 1'b0;
         restore_ff  <= 1'b1;
         shown_ff    <= {CELL_COUNT{CHAR_EMPTY}};
      end else begin
         fmode_ff    <= fmode_in;
         s1_valid_ff <= s1_valid_in;
         restore_ff  <= restore_in;
         shown_ff    <= shown_in;
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff   <= req_tuser;
         s1_failed_ff <= req_tdata[17];
         s1_v_ff      <= v_sat;
         s1_hum_ff    <= hum_sat;
      end
   end

endmodule
`default_nettype wire

>>> design/lhdu_queue.sv
// Small work queue between the front end and the write sequencer.
`default_nettype none
module lhdu_queue #(
   parameter int DEPTH = lhdu_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  lhdu_pkg::q_entry_type push_entry,
   input  logic                  pop,
   output logic                  head_valid,
   output lhdu_pkg::q_entry_type head_entry,
   output logic                  full
);
   import lhdu_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   q_entry_type             slot_ff [DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

>>> design/lhdu_back.sv
// Back end: turns queued work into column writes, one per cycle while rsp_tready allows.
`default_nettype none
module lhdu_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               head_valid,
   input  lhdu_pkg::q_entry_type              head_entry,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [3:0] column, [11:4] char_code, [15:12] zero
   output logic [lhdu_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                               rsp_tlast
);
   import lhdu_pkg::*;

   logic [STEP_COUNT-1:0]      pend_ff, pend_in, pend_next, low_bit;
   logic [CELL_COUNT-1:0][7:0] chars_ff, chars_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [3:0]                 col_ff, col_in;
   logic [7:0]                 code_ff, code_in;
   logic                       last_ff, last_in;
   logic                       slot_free, emit;
   logic [STEP_COUNT-1:0][7:0] step_char;

   // Pick the lowest pending write
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign emit      = (pend_ff != '0) && slot_free;
   assign low_bit   = pend_ff & (~pend_ff + 1'b1);
   assign pend_next = emit ? (pend_ff & ~low_bit) : pend_ff;

   always_comb begin
      for (int i = 0; i < FIXED_COUNT; i++) begin
         step_char[i] = FIXED_CHAR[i];
      end
      for (int i = 0; i < CELL_COUNT; i++) begin
         step_char[FIXED_COUNT + i] = chars_ff[i];
      end
      col_in  = col_ff;
      code_in = code_ff;
      last_in = last_ff;
      if (emit) begin
         col_in  = '0;
         code_in = '0;
         for (int i = 0; i < STEP_COUNT; i++) begin
            col_in  = col_in  | (low_bit[i] ? STEP_COLUMN[i] : 4'd0);
            code_in = code_in | (low_bit[i] ? step_char[i] : 8'd0);
         end
         last_in = (pend_next == '0);
      end
   end

   // Take the next entry as soon as the current one is used up
   assign pop      = head_valid && (pend_next == '0);
   assign pend_in  = pop ? {head_entry.mask, {FIXED_COUNT{head_entry.full}}} : pend_next;
   assign chars_in = pop ? head_entry.chars : chars_ff;
   assign rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
      col_ff   <= col_in;
      code_ff  <= code_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, code_ff, col_ff};
   assign rsp_tlast  = last_ff;

   // Queued work always carries at least one write
   a_entry_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (head_entry.full || (head_entry.mask != '0)))
      else $error("empty entry taken from queue");

   // Pending work with a free output slot shows up as a result next cycle
   a_pend_emits: assert property (@(posedge clock) disable iff (reset)
      ((pend_ff != '0) && slot_free) |=> rsp_tvalid)
      else $error("pending write not emitted");

   // A write not marked last leaves more writes of the same entry
   a_not_last_more: assert property (@(posedge clock) disable iff (reset)
      (emit && !last_in) |-> !$onehot(pend_ff))
      else $error("last marker lost");

endmodule
`default_nettype wire

>>> design/lcd_header_digit_updater.sv
// Top level of the LCD header digit updater.
// A request carries either a reading (temperature in tenths of a degree C, humidity in
// percent, sensor-fail flag) or, with tuser set, a mark-dirty event. Each reading yields
// the column writes for the digit cells that changed, the last one flagged by rsp_tlast;
// after reset or mark-dirty the next reading yields all nine writes (fixed symbols in
// columns 3, 5, 6, 9, then columns 1, 2, 4, 7, 8). Requests are taken one per cycle while
// the work queue (QUEUE_DEPTH entries) has room; the write sequencer delivers one result
// per cycle while rsp_tready is high, and a reading yields zero to nine writes. A request
// passes the front-end stage register, the queue, the pending register and the output
// register in turn. Fahrenheit mode is set through the csr port, which is always ready.
`default_nettype none
module lcd_header_digit_updater #(
   parameter int QUEUE_DEPTH = lhdu_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [9:0] temp_tenths_c, [16:10] humidity_pct, [17] sensor_failed, [23:18] zero
   input  logic [lhdu_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [0] kind
   input  logic                               req_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic                               csr_data,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [3:0] column, [11:4] char_code, [15:12] zero
   output logic [lhdu_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                               rsp_tlast
);
   import lhdu_pkg::*;

   logic        push_valid, q_full, head_valid, pop;
   q_entry_type push_entry, head_entry;

   lhdu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .q_full     (q_full)
   );

   lhdu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .full       (q_full)
   );

   lhdu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

>>> verif/lhdu_tb_pkg.sv
// Request kind codes shared by the LCD header updater testbench files.
package lhdu_tb_pkg;

   typedef enum logic {
      KIND_READING    = 1'b0,
      KIND_MARK_DIRTY = 1'b1
   } req_kind_type;

endpackage

>>> verif/lhdu_checker.sv
// Checker for the LCD header updater: tracks the display, predicts writes, compares them.
module lhdu_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [lhdu_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                               req_tuser,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic                               csr_data,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [lhdu_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                               rsp_tlast,
   output int unsigned                        writes_pending,
   output int unsigned                        fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import lhdu_pkg::*;
   import lhdu_tb_pkg::*;

   typedef struct packed {
      logic [3:0] column;
      logic [7:0] char_code;
      logic       last_write;
   } lcd_write_type;

   // Columns of the digit cells: temp tens, units, tenths, humidity tens, units
   localparam logic [CELL_COUNT-1:0][3:0] CELL_COL = {4'd8, 4'd7, 4'd4, 4'd2, 4'd1};

   lcd_write_type expected_writes[$];
   logic          fahrenheit_on;
   logic          redraw_pending;
   logic [7:0]    shown_cells [CELL_COUNT];

   // Work out the LCD writes caused by one reading and update the display copy
   task automatic predict_reading(input logic [9:0] temp, input logic [6:0] hum_in,
                                  input logic failed);
      int unsigned   v;
      int unsigned   hum;
      int unsigned   whole;
      int unsigned   frac;
      int            n;
      logic [7:0]    cells [CELL_COUNT];
      lcd_write_type batch [STEP_COUNT];
      n = 0;
      if (failed) begin
         for (int i = 0; i < CELL_COUNT; i++) cells[i] = CHAR_DASH;
      end else begin
         v = temp;
         if (fahrenheit_on) v = (18 * v + 5) / 10 + 320;
         if (v > 999) v = 999;
         hum = hum_in;
         if (hum > 99) hum = 99;
         whole = v / 10;
         frac  = v % 10;
         cells[0] = (whole >= 10) ? {DIGIT_HI, 4'(whole / 10)} : CHAR_SPACE;
         cells[1] = {DIGIT_HI, 4'(whole % 10)};
         cells[2] = {DIGIT_HI, 4'(frac)};
         cells[3] = (hum >= 10) ? {DIGIT_HI, 4'(hum / 10)} : CHAR_SPACE;
         cells[4] = {DIGIT_HI, 4'(hum % 10)};
      end
      if (redraw_pending) begin
         redraw_pending = 1'b0;
         batch[0] = '{column: 4'd3, char_code: CHAR_DOT,     last_write: 1'b0};
         batch[1] = '{column: 4'd5, char_code: CHAR_DEGREE,  last_write: 1'b0};
         batch[2] = '{column: 4'd6, char_code: CHAR_SPACE,   last_write: 1'b0};
         batch[3] = '{column: 4'd9, char_code: CHAR_PERCENT, last_write: 1'b0};
         n = 4;
         for (int i = 0; i < CELL_COUNT; i++) begin
            batch[n] = '{column: CELL_COL[i], char_code: cells[i], last_write: 1'b0};
            n++;
            shown_cells[i] = cells[i];
         end
      end else begin
         for (int i = 0; i < CELL_COUNT; i++) begin
            if (cells[i] != shown_cells[i]) begin
               batch[n] = '{column: CELL_COL[i], char_code: cells[i], last_write: 1'b0};
               n++;
               shown_cells[i] = cells[i];
            end
         end
      end
      // final write of the batch carries the last flag
      for (int i = 0; i < n; i++) begin
         batch[i].last_write = (i == n - 1);
         expected_writes.push_back(batch[i]);
      end
   endtask

   // Watch all three channels; writes are checked before new requests are predicted
   always @(posedge clock) begin : watch
      lcd_write_type want;
      if (reset) begin
         fahrenheit_on  = 1'b0;
         redraw_pending = 1'b1;
         fail_count     = 0;
         for (int i = 0; i < CELL_COUNT; i++) shown_cells[i] = CHAR_EMPTY;
         expected_writes.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_writes.size() == 0) begin
               $error("unexpected write: column %0d, char_code 'h%02h, last_write %0b",
                      rsp_tdata[3:0], rsp_tdata[11:4], rsp_tlast);
               fail_count++;
            end else begin
               want = expected_writes.pop_front();
               if (rsp_tdata[3:0] !== want.column) begin
                  $error("column: expected %0d, actual %0d", want.column, rsp_tdata[3:0]);
                  fail_count++;
               end
               if (rsp_tdata[11:4] !== want.char_code) begin
                  $error("char_code: expected 'h%02h, actual 'h%02h",
                         want.char_code, rsp_tdata[11:4]);
                  fail_count++;
               end
               if (rsp_tlast !== want.last_write) begin
                  $error("last_write: expected %0b, actual %0b", want.last_write, rsp_tlast);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) fahrenheit_on = csr_data;
         if (req_tvalid && req_tready) begin
            if (req_tuser == KIND_MARK_DIRTY) redraw_pending = 1'b1;
            else predict_reading(req_tdata[9:0], req_tdata[16:10], req_tdata[17]);
         end
      end
      writes_pending <= expected_writes.size();
   end

endmodule

>>> verif/tb_lcd_header_digit_updater.sv
// Testbench top for the LCD header updater: clock, reset, stimulus and verdict.
module tb_lcd_header_digit_updater;
   timeunit 1ns;
   timeprecision 1ps;

   import lhdu_pkg::*;
   import lhdu_tb_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 10;
   localparam int PHASE_ITEMS   = 70;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_TDATA_W-1:0]   req_tdata  = '0;
   logic                     req_tuser  = KIND_READING;
   logic                     csr_valid  = 1'b0;
   logic                     csr_ready;
   logic                     csr_data   = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]   rsp_tdata;
   logic                     rsp_tlast;

   int unsigned writes_pending;
   int unsigned fail_count;
   int unsigned cycle_count = 0;
   int unsigned stall_left  = 0;
   logic        quiet       = 1'b0;
   logic [9:0]  last_temp   = '0;
   logic [6:0]  last_hum    = '0;

   lcd_header_digit_updater dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   lhdu_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .writes_pending (writes_pending),
      .fail_count     (fail_count)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Write receiver: random stall bursts, none when quiet
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Send one request, with an optional idle burst in front of it
   task automatic send_req(input req_kind_type kind, input logic [9:0] temp,
                           input logic [6:0] hum, input logic failed);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'd0, failed, hum, temp};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Wait until every predicted write has arrived and the pipeline has settled
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (writes_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic fahrenheit);
      csr_valid <= 1'b1;
      csr_data  <= fahrenheit;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random request: readings near the previous one or fully random, some edges, dirty and failures
   task automatic send_random;
      int unsigned pick;
      int          t;
      int          h;
      pick = $urandom_range(0, 99);
      t    = $urandom_range(0, 1023);
      h    = $urandom_range(0, 127);
      if (pick < 6) begin
         send_req(KIND_MARK_DIRTY, 10'(t), 7'(h), 1'($urandom_range(0, 1)));
      end else if (pick < 16) begin
         send_req(KIND_READING, 10'(t), 7'(h), 1'b1);
      end else begin
         if (pick < 55) begin
            t = int'(last_temp) + int'($urandom_range(0, 6)) - 3;
            h = int'(last_hum) + int'($urandom_range(0, 2)) - 1;
            if (t < 0) t = 0;
            if (t > 1023) t = 1023;
            if (h < 0) h = 0;
            if (h > 127) h = 127;
         end else if (pick < 65) begin
            case ($urandom_range(0, 8))
               0: t = 0;
               1: t = 99;
               2: t = 100;
               3: t = 376;
               4: t = 377;
               5: t = 378;
               6: t = 999;
               7: t = 1000;
               default: t = 1023;
            endcase
            case ($urandom_range(0, 5))
               0: h = 0;
               1: h = 9;
               2: h = 10;
               3: h = 99;
               4: h = 100;
               default: h = 127;
            endcase
         end
         last_temp = 10'(t);
         last_hum  = 7'(h);
         send_req(KIND_READING, 10'(t), 7'(h), 1'b0);
      end
   endtask

   // Stimulus
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Celsius: first reading redraws everything
      write_mode(1'b0);
      send_req(KIND_READING, 10'd0, 7'd0, 1'b0);
      send_req(KIND_READING, 10'd1023, 7'd127, 1'b0);
      send_req(KIND_READING, 10'd99, 7'd9, 1'b0);
      send_req(KIND_READING, 10'd99, 7'd9, 1'b0);
      send_req(KIND_READING, 10'd100, 7'd10, 1'b0);
      send_req(KIND_READING, 10'd999, 7'd99, 1'b0);
      send_req(KIND_READING, 10'd1000, 7'd100, 1'b0);
      send_req(KIND_READING, 10'd1023, 7'd127, 1'b1);
      send_req(KIND_READING, 10'd0, 7'd0, 1'b1);
      send_req(KIND_MARK_DIRTY, 10'd0, 7'd0, 1'b0);
      send_req(KIND_READING, 10'd555, 7'd42, 1'b0);
      send_req(KIND_MARK_DIRTY, 10'd1023, 7'd127, 1'b1);
      send_req(KIND_MARK_DIRTY, 10'd0, 7'd0, 1'b0);
      send_req(KIND_READING, 10'd555, 7'd42, 1'b0);
      send_req(KIND_READING, 10'd682, 7'd85, 1'b0);
      drain();

      // Fahrenheit: offset, saturation boundary
      write_mode(1'b1);
      send_req(KIND_READING, 10'd0, 7'd0, 1'b0);
      send_req(KIND_READING, 10'd376, 7'd50, 1'b0);
      send_req(KIND_READING, 10'd377, 7'd50, 1'b0);
      send_req(KIND_READING, 10'd378, 7'd50, 1'b0);
      send_req(KIND_READING, 10'd1023, 7'd127, 1'b0);
      send_req(KIND_MARK_DIRTY, 10'd0, 7'd0, 1'b0);
      send_req(KIND_READING, 10'd1, 7'd1, 1'b1);
      send_req(KIND_READING, 10'd5, 7'd3, 1'b0);
      drain();

      // Random phases, switching the scale between them; last phase has no idling
      for (int ph = 0; ph < 5; ph++) begin
         write_mode((ph == 4) ? 1'($urandom_range(0, 1)) : 1'(ph % 2));
         if (ph == 4) quiet <= 1'b1;
         repeat (PHASE_ITEMS) send_random();
         drain();
      end

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
